// ----- design/chunked_rle_memory_decoder_top_macros.svh -----
// Assertion macros for the chunked run-length memory decoder.
// Included by the top level; no other dependencies.
`ifndef CHUNKED_RLE_MEMORY_DECODER_TOP_MACROS_SVH
`define CHUNKED_RLE_MEMORY_DECODER_TOP_MACROS_SVH

`ifndef SYNTH
// Check a property at every rising clock edge outside reset.
`define CRLD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("crld assertion failed");
// Check that cond implies expr in the same cycle.
`define CRLD_ASSERT_IMP(lbl, clk, rst_n, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("crld implication failed");
`else
`define CRLD_ASSERT(lbl, clk, rst_n, prop)
`define CRLD_ASSERT_IMP(lbl, clk, rst_n, cond, expr)
`endif

`endif

// ----- design/crld_pkg.sv -----
// Shared types, phase codes and constants of the chunked RLE memory decoder.
// No dependencies.
package crld_pkg;

    localparam int PHASE_W = 3;

    localparam logic [PHASE_W-1:0] PH_NAME      = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SIZE      = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LIT       = 3'd2;
    localparam logic [PHASE_W-1:0] PH_ESC_COUNT = 3'd3;
    localparam logic [PHASE_W-1:0] PH_ESC_VALUE = 3'd4;
    localparam logic [PHASE_W-1:0] PH_SKIP      = 3'd5;
    localparam logic [PHASE_W-1:0] PH_ERROR     = 3'd6;

    localparam logic [7:0]  ESC_BYTE     = 8'hE5;
    localparam logic [31:0] RAW_MEM_SIZE = 32'h0001_0000;

    typedef struct packed {
        logic [15:0] write_address;
        logic [7:0]  write_value;
        logic [7:0]  run_length;
        logic        stream_done;
        logic        format_error;
    } crld_result_t;

    // Expected byte of the chunk name "MEM0".
    function automatic logic [7:0] mem_name_byte(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = 8'h4D;  // 'M'
            2'd1:    ch = 8'h45;  // 'E'
            2'd2:    ch = 8'h4D;  // 'M'
            default: ch = 8'h30;  // '0'
        endcase
        return ch;
    endfunction

endpackage

// ----- design/crld_in_stage.sv -----
// Input register of the decoder: holds one word between the link and the core.
// Depends on crld_pkg (none of its contents needed beyond the import convention).
module crld_in_stage
    import crld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       advance,
    output logic       item_valid,
    output logic [7:0] item_data,
    output logic       item_last
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       take;

    assign in_stall = valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item_data  = data_reg;
    assign item_last  = last_reg;

endmodule

// ----- design/crld_core.sv -----
// Chunk walker and run-length decoder: state registers and one-word update logic.
// Depends on crld_pkg for phase codes, constants and the result type.
module crld_core
    import crld_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  logic [7:0]   item_data,
    input  logic         item_last,
    output logic         res_valid,
    output crld_result_t res
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [1:0]         idx_reg, idx_next;
    logic               match_reg, match_next;
    logic [31:0]        len_reg, len_next;
    logic [15:0]        addr_reg, addr_next;
    logic [7:0]         pend_reg, pend_next;

    logic [31:0] size_acc;
    logic [31:0] len_dec;
    logic        run;
    logic        err;
    logic        was_error;
    logic [7:0]  r_val;
    logic [7:0]  r_len;
    logic [15:0] addr_step;

    // Size field arrives little-endian; upper bytes are still zero here.
    assign size_acc  = len_reg | ({24'd0, item_data} << {idx_reg, 3'b000});
    assign len_dec   = len_reg - 32'd1;
    assign was_error = (phase_reg == PH_ERROR);

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        match_next = match_reg;
        len_next   = len_reg;
        addr_next  = addr_reg;
        pend_next  = pend_reg;
        run        = 1'b0;
        err        = 1'b0;
        r_val      = 8'd0;
        r_len      = 8'd0;

        unique case (phase_reg) inside
            PH_SIZE:
            begin
                len_next = size_acc;
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    if (match_reg && size_acc == RAW_MEM_SIZE)
                    begin
                        phase_next = PH_ERROR;
                        err        = 1'b1;
                    end
                    else if (size_acc == 32'd0)
                    begin
                        phase_next = PH_NAME;
                    end
                    else if (match_reg)
                    begin
                        addr_next  = 16'd0;
                        phase_next = PH_LIT;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                    match_next = 1'b1;
                end
            end
            PH_LIT, PH_ESC_COUNT, PH_ESC_VALUE:
            begin
                if (phase_reg == PH_LIT)
                begin
                    if (item_data == ESC_BYTE)
                    begin
                        phase_next = PH_ESC_COUNT;
                    end
                    else
                    begin
                        run   = 1'b1;
                        r_val = item_data;
                        r_len = 8'd1;
                    end
                end
                else if (phase_reg == PH_ESC_COUNT)
                begin
                    if (item_data == 8'd0)
                    begin
                        run        = 1'b1;
                        r_val      = ESC_BYTE;
                        r_len      = 8'd1;
                        phase_next = PH_LIT;
                    end
                    else
                    begin
                        pend_next  = item_data;
                        phase_next = PH_ESC_VALUE;
                    end
                end
                else
                begin
                    run        = 1'b1;
                    r_val      = item_data;
                    r_len      = pend_reg;
                    phase_next = PH_LIT;
                end
                if (run)
                begin
                    addr_next = addr_reg + {8'd0, r_len};
                end
                len_next = len_dec;
                // Drop any escape cut off by the body end.
                if (len_dec == 32'd0)
                begin
                    phase_next = PH_NAME;
                    idx_next   = 2'd0;
                end
            end
            PH_SKIP:
            begin
                len_next = len_dec;
                if (len_dec == 32'd0)
                begin
                    phase_next = PH_NAME;
                    idx_next   = 2'd0;
                end
            end
            PH_ERROR:
            begin
                // Swallow everything up to the last word.
            end
            default:
            begin
                // Name phase, and the unused code.
                if (item_data != mem_name_byte(idx_reg))
                begin
                    match_next = 1'b0;
                end
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    phase_next = PH_SIZE;
                    len_next   = 32'd0;
                end
            end
        endcase

        addr_step = addr_next;

        if (item_last)
        begin
            phase_next = PH_NAME;
            idx_next   = 2'd0;
            match_next = 1'b1;
            len_next   = 32'd0;
            addr_next  = 16'd0;
            pend_next  = 8'd0;
        end
    end

    assign res_valid = err || run || (item_last && !was_error);

    always_comb
    begin
        // Status-only results report the address after this word.
        res.write_address = run ? addr_reg : addr_step;
        res.write_value   = r_val;
        res.run_length    = r_len;
        res.stream_done   = item_last && !was_error && !err;
        res.format_error  = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NAME;
            idx_reg   <= 2'd0;
            match_reg <= 1'b1;
            len_reg   <= 32'd0;
            addr_reg  <= 16'd0;
            pend_reg  <= 8'd0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            match_reg <= match_next;
            len_reg   <= len_next;
            addr_reg  <= addr_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

// ----- design/crld_out_stage.sv -----
// Result register of the decoder: holds one result word until the sink takes it.
// Depends on crld_pkg for the result type.
module crld_out_stage
    import crld_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  crld_result_t res,
    output logic         ready,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [15:0]  write_address,
    output logic [7:0]   write_value,
    output logic [7:0]   run_length,
    output logic         stream_done,
    output logic         format_error
);

    logic         valid_reg;
    logic         valid_next;
    crld_result_t res_reg;

    // Free when empty or when the held word leaves this cycle.
    assign ready = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = valid_reg;
    assign write_address = res_reg.write_address;
    assign write_value   = res_reg.write_value;
    assign run_length    = res_reg.run_length;
    assign stream_done   = res_reg.stream_done;
    assign format_error  = res_reg.format_error;

endmodule

// ----- design/chunked_rle_memory_decoder_top.sv -----
// Top level of the chunked run-length memory decoder.
// Depends on crld_pkg, crld_in_stage, crld_core, crld_out_stage and the macros header.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------------
//   input   | in_valid / in_stall  | data_byte, last_byte
//   output  | out_valid / out_stall| write_address, write_value, run_length,
//           |                      | stream_done, format_error
//
// One word per cycle while the output does not stall; each word is held in the
// input register, and the chunk/RLE update loads any result into the result register.
// The result register takes the next result in the cycle it is drained, so a
// stalled output holds the input register and then stalls the input.
// Reset is asynchronous; afterward the block waits for a chunk name.
`include "chunked_rle_memory_decoder_top_macros.svh"

module chunked_rle_memory_decoder_top
    import crld_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] write_address,
    output logic [7:0]  write_value,
    output logic [7:0]  run_length,
    output logic        stream_done,
    output logic        format_error
);

    logic         item_valid;
    logic [7:0]   item_data;
    logic         item_last;
    logic         out_ready;
    logic         fire;
    logic         res_valid;
    crld_result_t res;

    assign fire = item_valid && out_ready;

    crld_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .advance    (out_ready),
        .item_valid (item_valid),
        .item_data  (item_data),
        .item_last  (item_last)
    );

    crld_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item_data (item_data),
        .item_last (item_last),
        .res_valid (res_valid),
        .res       (res)
    );

    crld_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (fire && res_valid),
        .res           (res),
        .ready         (out_ready),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .write_address (write_address),
        .write_value   (write_value),
        .run_length    (run_length),
        .stream_done   (stream_done),
        .format_error  (format_error)
    );

    `CRLD_ASSERT(a_done_xor_err, clk, rst_n, !(out_valid && stream_done && format_error))
    `CRLD_ASSERT_IMP(a_status_flagged, clk, rst_n, out_valid && run_length == 8'd0,
        stream_done || format_error)
    `CRLD_ASSERT_IMP(a_hold_on_full, clk, rst_n, out_valid && out_stall && item_valid,
        in_stall && !fire)

endmodule
